[rtl/gtu_pkg.sv]
package gtu_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_DIMS_DEF   = 4;

   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_N_POINTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS     = 1'd1;

   localparam logic [6:0] N_POINTS_RESET = 7'd64;
   localparam logic [2:0] DIMS_RESET     = 3'd2;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_PAIR  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         point;
      logic [5:0]         other_point;
      logic [1:0]         dim;
      logic signed [31:0] coord;
      logic [30:0]        target_dist;
      logic [30:0]        current_dist;
   } gtu_req_type;

   typedef struct packed {
      logic signed [31:0] new_coord;
      logic               div_error;
      logic               saturated;
   } gtu_rsp_type;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_LOAD,
      KIND_PAIR,
      KIND_READ,
      KIND_READ_BAD,
      KIND_SKIP
   } gtu_kind_type;

   typedef struct packed {
      gtu_kind_type kind;
      gtu_req_type  req;
   } gtu_item_type;

   typedef struct packed {
      logic [6:0] n_points;
      logic [2:0] dims;
   } gtu_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gtu_div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROW_RD,
      ST_ROW_WR,
      ST_X_RD,
      ST_MUL,
      ST_ACC,
      ST_RD_RD,
      ST_RD_MUL,
      ST_RD_SUM,
      ST_RD_DIV,
      ST_RD_OUT
   } gtu_state_type;

endpackage

[rtl/gtu_front.sv]
module gtu_front #(
   parameter int MAX_POINTS = gtu_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS   = gtu_pkg::MAX_DIMS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gtu_pkg::gtu_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gtu_pkg::gtu_req_type req_data,
   output logic                 q_valid,
   input  logic                 q_pop,
   output gtu_pkg::gtu_item_type q_item
);

   gtu_pkg::gtu_item_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   gtu_pkg::gtu_item_type item;
   int         np, nd;
   logic       pt_ok, d_ok;

   always_comb begin
      np = (int'(cfg.n_points) > MAX_POINTS) ? MAX_POINTS : int'(cfg.n_points);
      nd = (int'(cfg.dims) > MAX_DIMS) ? MAX_DIMS : int'(cfg.dims);
      pt_ok = int'(req_data.point) < np;
      d_ok  = int'(req_data.dim) < nd;
      item.req = req_data;
      case (req_data.op)
         gtu_pkg::OP_CLEAR: item.kind = gtu_pkg::KIND_CLEAR;
         gtu_pkg::OP_LOAD: begin
            item.kind = (pt_ok && d_ok) ? gtu_pkg::KIND_LOAD : gtu_pkg::KIND_SKIP;
         end
         gtu_pkg::OP_PAIR: begin
            item.kind = (pt_ok && req_data.point > req_data.other_point) ?
                        gtu_pkg::KIND_PAIR : gtu_pkg::KIND_SKIP;
         end
         default: begin
            item.kind = (pt_ok && d_ok) ? gtu_pkg::KIND_READ : gtu_pkg::KIND_READ_BAD;
         end
      endcase
   end

   assign req_stall = cnt_ff == 2'd2;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = q_mem_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[rtl/gtu_div.sv]
module gtu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [63:0]                 dividend,
   input  logic [30:0]                 divisor,
   output gtu_pkg::gtu_div_status_type stat,
   output logic [63:0]                 quotient
);

   logic [6:0]  cnt_ff;
   logic        done_ff;
   logic [63:0] q_ff;
   logic [30:0] rem_ff;
   logic [30:0] div_ff;
   logic [31:0] sh, diff;
   logic        ge;

   always_comb begin
      sh   = {rem_ff, q_ff[63]};
      ge   = sh >= {1'b0, div_ff};
      diff = sh - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 7'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= 7'd64;
         end else if (cnt_ff != 7'd0) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= 31'd0;
         div_ff <= divisor;
      end else if (cnt_ff != 7'd0) begin
         rem_ff <= ge ? diff[30:0] : sh[30:0];
         q_ff   <= {q_ff[62:0], ge};
      end
   end

   assign stat.busy = cnt_ff != 7'd0;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

[rtl/gtu_back.sv]
module gtu_back #(
   parameter int MAX_POINTS = gtu_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS   = gtu_pkg::MAX_DIMS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gtu_pkg::gtu_cfg_type        cfg,
   input  logic                        q_valid,
   input  gtu_pkg::gtu_item_type       q_item,
   output logic                        q_pop,
   output logic                        div_start,
   output logic [63:0]                 div_dividend,
   output logic [30:0]                 div_divisor,
   input  gtu_pkg::gtu_div_status_type div_stat,
   input  logic [63:0]                 div_quot,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output gtu_pkg::gtu_rsp_type        rsp_data
);

   localparam int DEPTH = MAX_POINTS * MAX_DIMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_POINTS);
   localparam int KW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   function automatic logic [AW-1:0] cidx(input int p, input int d);
      return AW'(p * MAX_DIMS + d);
   endfunction

   logic [31:0] x_mem     [DEPTH];
   logic [47:0] row_mem   [MAX_POINTS];
   logic [47:0] cross_mem [DEPTH];
   logic [MAX_POINTS-1:0] row_vld_ff;
   logic [DEPTH-1:0]      cross_vld_ff;

   gtu_pkg::gtu_state_type state_ff, state_in;
   logic          sel_ff, sel_in;
   logic [KW-1:0] k_ff, k_in;
   logic          err_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   gtu_pkg::gtu_rsp_type rsp_data_ff;

   gtu_pkg::gtu_req_type item_ff;
   logic [31:0] ratio_ff;
   logic [63:0] prod_ff, phi_ff, plo_ff;
   logic        xneg_ff, dneg_ff;
   logic [31:0] res_ff;
   logic        sat_ff;
   logic [31:0] x_rd_ff;
   logic [47:0] row_rd_ff, cr_rd_ff;
   logic        row_rv_ff, cr_rv_ff;

   int          nd_int;
   logic [5:0]  pt_a, pt_b;
   logic        x_re, cr_re, row_re, cr_we, row_we, x_we;
   logic [AW-1:0] x_raddr, cr_raddr, x_waddr;
   logic [PW-1:0] row_raddr;
   logic          rsp_load, do_clear, take;
   logic [47:0] row_val, row_new, cr_val, cr_new;
   logic [48:0] row_sum;
   logic [31:0] xmag;
   logic signed [49:0] v50, s50, c50;
   logic [63:0] t_sum, t_clamp, dmag;
   logic signed [63:0] term, diff;
   logic [31:0] q_res;
   logic        q_sat;
   logic [6:0]  div_n;

   always_comb begin
      nd_int  = (int'(cfg.dims) > MAX_DIMS) ? MAX_DIMS : int'(cfg.dims);
      pt_a    = sel_ff ? item_ff.other_point : item_ff.point;
      pt_b    = sel_ff ? item_ff.point : item_ff.other_point;
      div_n   = (cfg.n_points == 7'd0) ? 7'd1 : cfg.n_points;
      row_val = row_rv_ff ? row_rd_ff : 48'd0;
      cr_val  = cr_rv_ff ? cr_rd_ff : 48'd0;
      xmag    = x_rd_ff[31] ? (~x_rd_ff + 32'd1) : x_rd_ff;
      row_sum = {1'b0, row_val} + {17'd0, ratio_ff};
      row_new = row_sum[48] ? {48{1'b1}} : row_sum[47:0];
      v50     = xneg_ff ? -$signed({2'b00, prod_ff[63:16]}) : $signed({2'b00, prod_ff[63:16]});
      c50     = $signed({{2{cr_val[47]}}, cr_val});
      s50     = c50 + v50;
      if (s50 > $signed(50'h0_7FFF_FFFF_FFFF)) begin
         cr_new = 48'h7FFF_FFFF_FFFF;
      end else if (s50 < $signed({2'b11, 48'h8000_0000_0000})) begin
         cr_new = 48'h8000_0000_0000;
      end else begin
         cr_new = s50[47:0];
      end
      t_sum   = phi_ff + (plo_ff >> 16);
      t_clamp = (t_sum > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : t_sum;
      term    = xneg_ff ? -$signed(t_clamp) : $signed(t_clamp);
      diff    = term - $signed({{16{cr_val[47]}}, cr_val});
      dmag    = diff[63] ? (~diff + 64'd1) : diff;
      if (!dneg_ff) begin
         q_sat = div_quot > 64'h7FFF_FFFF;
         q_res = q_sat ? 32'h7FFF_FFFF : div_quot[31:0];
      end else begin
         q_sat = div_quot > 64'h8000_0000;
         q_res = q_sat ? 32'h8000_0000 : (~div_quot[31:0] + 32'd1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      k_in         = k_ff;
      q_pop        = 1'b0;
      take         = 1'b0;
      div_start    = 1'b0;
      div_dividend = {1'b0, dmag[62:0]};
      div_divisor  = {24'd0, div_n};
      x_re         = 1'b0;
      cr_re        = 1'b0;
      row_re       = 1'b0;
      x_we         = 1'b0;
      cr_we        = 1'b0;
      row_we       = 1'b0;
      do_clear     = 1'b0;
      rsp_load     = 1'b0;
      x_raddr      = cidx(int'(item_ff.point), int'(item_ff.dim));
      cr_raddr     = cidx(int'(item_ff.point), int'(item_ff.dim));
      x_waddr      = cidx(int'(q_item.req.point), int'(q_item.req.dim));
      row_raddr    = PW'(item_ff.point);
      case (state_ff)
         gtu_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               take  = 1'b1;
               case (q_item.kind)
                  gtu_pkg::KIND_CLEAR: do_clear = 1'b1;
                  gtu_pkg::KIND_LOAD: x_we = 1'b1;
                  gtu_pkg::KIND_PAIR: begin
                     sel_in = 1'b0;
                     if (q_item.req.current_dist == 31'd0) begin
                        state_in = gtu_pkg::ST_ROW_RD;
                     end else begin
                        div_start    = 1'b1;
                        div_dividend = {17'd0, q_item.req.target_dist, 16'd0};
                        div_divisor  = q_item.req.current_dist;
                        state_in     = gtu_pkg::ST_DIV;
                     end
                  end
                  gtu_pkg::KIND_READ: state_in = gtu_pkg::ST_RD_RD;
                  gtu_pkg::KIND_READ_BAD: state_in = gtu_pkg::ST_RD_OUT;
                  default: state_in = gtu_pkg::ST_IDLE;
               endcase
            end
         end
         gtu_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = gtu_pkg::ST_ROW_RD;
            end
         end
         gtu_pkg::ST_ROW_RD: begin
            row_re    = 1'b1;
            row_raddr = PW'(pt_a);
            state_in  = gtu_pkg::ST_ROW_WR;
         end
         gtu_pkg::ST_ROW_WR: begin
            row_we    = 1'b1;
            row_raddr = PW'(pt_a);
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = gtu_pkg::ST_ROW_RD;
            end else begin
               sel_in   = 1'b0;
               k_in     = '0;
               state_in = (nd_int == 0) ? gtu_pkg::ST_IDLE : gtu_pkg::ST_X_RD;
            end
         end
         gtu_pkg::ST_X_RD: begin
            x_re     = 1'b1;
            cr_re    = 1'b1;
            x_raddr  = cidx(int'(pt_b), int'(k_ff));
            cr_raddr = cidx(int'(pt_a), int'(k_ff));
            state_in = gtu_pkg::ST_MUL;
         end
         gtu_pkg::ST_MUL: state_in = gtu_pkg::ST_ACC;
         gtu_pkg::ST_ACC: begin
            cr_we    = 1'b1;
            cr_raddr = cidx(int'(pt_a), int'(k_ff));
            state_in = gtu_pkg::ST_X_RD;
            if (!sel_ff) begin
               sel_in = 1'b1;
            end else begin
               sel_in = 1'b0;
               if (int'(k_ff) + 1 >= nd_int) begin
                  state_in = gtu_pkg::ST_IDLE;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         gtu_pkg::ST_RD_RD: begin
            x_re     = 1'b1;
            cr_re    = 1'b1;
            row_re   = 1'b1;
            state_in = gtu_pkg::ST_RD_MUL;
         end
         gtu_pkg::ST_RD_MUL: state_in = gtu_pkg::ST_RD_SUM;
         gtu_pkg::ST_RD_SUM: begin
            div_start = 1'b1;
            state_in  = gtu_pkg::ST_RD_DIV;
         end
         gtu_pkg::ST_RD_DIV: begin
            if (div_stat.done) begin
               state_in = gtu_pkg::ST_RD_OUT;
            end
         end
         gtu_pkg::ST_RD_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = gtu_pkg::ST_IDLE;
            end
         end
         default: state_in = gtu_pkg::ST_IDLE;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtu_pkg::ST_IDLE;
         sel_ff       <= 1'b0;
         k_ff         <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         cross_vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_clear) begin
            err_ff       <= 1'b0;
            row_vld_ff   <= '0;
            cross_vld_ff <= '0;
         end else begin
            if (take && q_item.kind == gtu_pkg::KIND_PAIR &&
                q_item.req.current_dist == 31'd0) begin
               err_ff <= 1'b1;
            end
            if (row_we) begin
               row_vld_ff[row_raddr] <= 1'b1;
            end
            if (cr_we) begin
               cross_vld_ff[cr_raddr] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[x_waddr] <= q_item.req.coord;
      end
      if (x_re) begin
         x_rd_ff <= x_mem[x_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_raddr] <= row_new;
      end
      if (row_re) begin
         row_rd_ff <= row_mem[row_raddr];
         row_rv_ff <= row_vld_ff[row_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cr_we) begin
         cross_mem[cr_raddr] <= cr_new;
      end
      if (cr_re) begin
         cr_rd_ff <= cross_mem[cr_raddr];
         cr_rv_ff <= cross_vld_ff[cr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff  <= q_item.req;
         ratio_ff <= 32'd0;
         res_ff   <= 32'd0;
         sat_ff   <= 1'b0;
      end
      if (state_ff == gtu_pkg::ST_DIV && div_stat.done) begin
         ratio_ff <= (div_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quot[31:0];
      end
      if (state_ff == gtu_pkg::ST_MUL) begin
         prod_ff <= 64'(ratio_ff) * 64'(xmag);
         xneg_ff <= x_rd_ff[31];
      end
      if (state_ff == gtu_pkg::ST_RD_MUL) begin
         phi_ff  <= 64'(row_val) * 64'(xmag[31:16]);
         plo_ff  <= 64'(row_val) * 64'(xmag[15:0]);
         xneg_ff <= x_rd_ff[31];
      end
      if (state_ff == gtu_pkg::ST_RD_SUM) begin
         dneg_ff <= diff[63];
      end
      if (state_ff == gtu_pkg::ST_RD_DIV && div_stat.done) begin
         res_ff <= q_res;
         sat_ff <= q_sat;
      end
      if (rsp_load) begin
         rsp_data_ff <= '{new_coord: res_ff, div_error: err_ff, saturated: sat_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy) else $error("divider restarted while busy");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == gtu_pkg::ST_IDLE) else $error("queue popped while busy");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid && state_ff == gtu_pkg::ST_IDLE))
      else $error("result not presented after load");

   a_div_done_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gtu_pkg::ST_DIV && div_stat.done) |=> state_ff == gtu_pkg::ST_ROW_RD)
      else $error("pair did not proceed after ratio");

endmodule

[rtl/guttman_transform_unweighted_core.sv]
// unweighted guttman transform core, q16.16 fixed point
// req channel: req_valid/req_stall/req_data carry one op item per transfer
//   (clear sums, load coordinate, pair distances, read new coordinate)
// rsp channel: rsp_valid/rsp_stall/rsp_data, one transfer per read item
// csr port: csr_we with csr_index 0 = n_points, 1 = dims, data in csr_wdata
// a two entry queue behind the front classifier lets items arrive while the
//   back end works; the back end executes one item at a time
// clear and load are done as the back end takes them; invalid loads and pairs
//   are dropped, an invalid read still returns a result
// pair: serial ratio divide (skipped for zero distance), then the two row
//   sums, then a cross sum update (read, multiply, accumulate) for each point
//   of the pair in every dim
// read: memory reads and multiplies, then a serial divide by n_points; the
//   result goes to the output register once it is free
// reset clears sums, error flag, queue and result valid flag; coordinates are
//   undefined until loaded; n_points resets to 64 and dims to 2
// a stalled result holds in the output register; the back end waits to load
//   the next result while the queue keeps accepting until full
module guttman_transform_unweighted_core #(
   parameter int MAX_POINTS = gtu_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS   = gtu_pkg::MAX_DIMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gtu_pkg::gtu_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gtu_pkg::gtu_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [gtu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gtu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   gtu_pkg::gtu_cfg_type        cfg_ff;
   logic                        q_valid, q_pop;
   gtu_pkg::gtu_item_type       q_item;
   logic                        div_start;
   logic [63:0]                 div_dividend, div_quot;
   logic [30:0]                 div_divisor;
   gtu_pkg::gtu_div_status_type div_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.n_points <= gtu_pkg::N_POINTS_RESET;
         cfg_ff.dims     <= gtu_pkg::DIMS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            gtu_pkg::CSR_N_POINTS: cfg_ff.n_points <= csr_wdata[6:0];
            gtu_pkg::CSR_DIMS: cfg_ff.dims <= csr_wdata[2:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   gtu_front #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   gtu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   gtu_back #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_stat     (div_stat),
      .div_quot     (div_quot),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
